// ===== design/dual_mode_transition_sequencer_defines.svh =====
// assertion macros for the dual mode transition sequencer checker
// needs clk and rst_n in the scope where a macro is used
`ifndef DUAL_MODE_TRANSITION_SEQUENCER_DEFINES_SVH
`define DUAL_MODE_TRANSITION_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MDTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MDTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mdts_pkg.sv =====
// shared types and codes for the dual mode transition sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mdts_pkg;

    localparam int ACTION_BITS = 3;

    localparam logic [ACTION_BITS-1:0] ACT_FG_REQ = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_BG_REQ = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_TICK   = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_ENTER  = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_LEAVE  = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_SAVE   = 3'd5;
    localparam logic [ACTION_BITS-1:0] ACT_POP    = 3'd6;

    // per-channel commands
    typedef struct packed {
        logic req;
        logic adv;
    } chan_ctl_t;

    // per history cell controls
    typedef struct packed {
        logic shift_up;
        logic live;
    } hcell_ctl_t;

endpackage

`default_nettype wire

// ===== design/mdts_channel.sv =====
// one channel of mode registers: request, goal, current, last, saved
// depends on mdts_pkg
`timescale 1ns / 1ps
`default_nettype none

module mdts_channel
    import mdts_pkg::*;
#(
    parameter int MODE_BITS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  chan_ctl_t            ctl,
    input  logic [MODE_BITS-1:0] mode,
    output logic [MODE_BITS-1:0] req,
    output logic [MODE_BITS-1:0] goal,
    output logic [MODE_BITS-1:0] cur,
    output logic [MODE_BITS-1:0] last,
    output logic [MODE_BITS-1:0] saved
);

    localparam logic [MODE_BITS-1:0] NONE = '0;

    logic [MODE_BITS-1:0] req_reg, req_next;
    logic [MODE_BITS-1:0] goal_reg, goal_next;
    logic [MODE_BITS-1:0] cur_reg, cur_next;
    logic [MODE_BITS-1:0] last_reg, last_next;
    logic [MODE_BITS-1:0] saved_reg, saved_next;

    always_comb
    begin
        req_next   = req_reg;
        goal_next  = goal_reg;
        cur_next   = cur_reg;
        last_next  = last_reg;
        saved_next = saved_reg;
        if (ctl.req)
        begin
            if (mode != NONE && mode != cur_reg)
            begin
                req_next = mode;
            end
        end
        else if (ctl.adv)
        begin
            if (last_reg != NONE)
            begin
                saved_next = last_reg;
                last_next  = NONE;
            end
            if (goal_reg != NONE)
            begin
                last_next = cur_reg;
                cur_next  = goal_reg;
            end
            // request always drops into goal, empty or not
            goal_next = req_reg;
            req_next  = NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg   <= '0;
            goal_reg  <= '0;
            cur_reg   <= '0;
            last_reg  <= '0;
            saved_reg <= '0;
        end
        else
        begin
            req_reg   <= req_next;
            goal_reg  <= goal_next;
            cur_reg   <= cur_next;
            last_reg  <= last_next;
            saved_reg <= saved_next;
        end
    end

    assign req   = req_reg;
    assign goal  = goal_reg;
    assign cur   = cur_reg;
    assign last  = last_reg;
    assign saved = saved_reg;

endmodule

`default_nettype wire

// ===== design/mdts_hist_cell.sv =====
// one entry of the mode history chain; a save token ripples down one cell per cycle
// depends on mdts_pkg
`timescale 1ns / 1ps
`default_nettype none

module mdts_hist_cell
    import mdts_pkg::*;
#(
    parameter int MODE_BITS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hcell_ctl_t           ctl,
    input  logic [MODE_BITS-1:0] key,
    input  logic [MODE_BITS-1:0] up_val,
    input  logic                 tok_in_valid,
    input  logic [MODE_BITS-1:0] tok_in_data,
    output logic [MODE_BITS-1:0] val,
    output logic                 tok_out_valid,
    output logic [MODE_BITS-1:0] tok_out_data,
    output logic                 absorbed
);

    logic [MODE_BITS-1:0] val_reg, val_next;
    logic                 tok_valid_reg, tok_valid_next;
    logic [MODE_BITS-1:0] tok_data_reg, tok_data_next;

    always_comb
    begin
        val_next       = val_reg;
        tok_valid_next = 1'b0;
        tok_data_next  = tok_data_reg;
        if (ctl.shift_up)
        begin
            val_next = up_val;
        end
        else if (tok_in_valid)
        begin
            val_next = tok_in_data;
            // a live entry equal to the key ends the ripple, as does an empty entry; any other live entry moves it on
            tok_valid_next = ctl.live && (val_reg != key);
            tok_data_next  = val_reg;
        end
    end

    // token landing on the first empty entry grows the history
    assign absorbed = tok_in_valid && !ctl.live;

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        tok_data_reg <= tok_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    assign val           = val_reg;
    assign tok_out_valid = tok_valid_reg;
    assign tok_out_data  = tok_data_reg;

endmodule

`default_nettype wire

// ===== design/dual_mode_transition_sequencer.sv =====
// top level of the dual mode transition sequencer: two mode channels and a history chain
// depends on mdts_pkg, mdts_channel, mdts_hist_cell
//
//  channel   signals                                   handshake
//  command   start, action, mode / busy                start high and busy low
//  result    done, fg_*, check_flag, popped_mode,      done high for one cycle
//            fell_back
//  config    cfg_valid, cfg_data / cfg_ready           cfg_valid and cfg_ready
//
// requests, tick, checks and unused actions: result in the next cycle, busy stays low
// save: busy while the token ripples down the cell chain, then the result
// pop: drops entries equal to fg current while busy; pops the next, else default_mode
// reset clears both channels and the history count; default_mode resets to 1
// the receiver cannot stall, so a result shows exactly once
`timescale 1ns / 1ps
`default_nettype none

module dual_mode_transition_sequencer
    import mdts_pkg::*;
#(
    parameter int HISTORY_DEPTH = 16,
    parameter int MODE_BITS     = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [ACTION_BITS-1:0] action,
    input  logic [MODE_BITS-1:0]   mode,
    output logic                   done,
    output logic [MODE_BITS-1:0]   fg_request,
    output logic [MODE_BITS-1:0]   fg_goal,
    output logic [MODE_BITS-1:0]   fg_current,
    output logic [MODE_BITS-1:0]   fg_previous,
    output logic [MODE_BITS-1:0]   fg_kept,
    output logic                   check_flag,
    output logic [MODE_BITS-1:0]   popped_mode,
    output logic                   fell_back,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MODE_BITS-1:0]   cfg_data
);

    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int STEP_W = $clog2(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAVE,
        ST_POP
    } state_t;

    state_t               state_reg, state_next;
    logic                 done_reg, done_next;
    logic                 flag_reg, flag_next;
    logic [MODE_BITS-1:0] popped_reg, popped_next;
    logic                 fell_reg, fell_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [MODE_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [MODE_BITS-1:0] default_reg;

    logic accept;
    logic enter_hit;
    logic leave_hit;
    logic shift_up;

    chan_ctl_t fg_ctl, bg_ctl;
    logic [MODE_BITS-1:0] bg_req, bg_goal, bg_cur, bg_last, bg_saved;

    hcell_ctl_t           cell_ctl  [HISTORY_DEPTH];
    logic [MODE_BITS-1:0] cell_val  [HISTORY_DEPTH];
    logic [MODE_BITS-1:0] tok_data  [HISTORY_DEPTH+1];
    logic [HISTORY_DEPTH:0]   tok_valid;
    logic [HISTORY_DEPTH-1:0] absorbed;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_reg <= MODE_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            default_reg <= cfg_data;
        end
    end

    // channels
    assign fg_ctl.req = accept && (action == ACT_FG_REQ);
    assign fg_ctl.adv = accept && (action == ACT_TICK);
    assign bg_ctl.req = accept && (action == ACT_BG_REQ);
    assign bg_ctl.adv = accept && (action == ACT_TICK);

    mdts_channel #(.MODE_BITS(MODE_BITS)) u_fg (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fg_ctl),
        .mode  (mode),
        .req   (fg_request),
        .goal  (fg_goal),
        .cur   (fg_current),
        .last  (fg_previous),
        .saved (fg_kept)
    );

    mdts_channel #(.MODE_BITS(MODE_BITS)) u_bg (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bg_ctl),
        .mode  (mode),
        .req   (bg_req),
        .goal  (bg_goal),
        .cur   (bg_cur),
        .last  (bg_last),
        .saved (bg_saved)
    );

    assign enter_hit = (fg_goal == mode || bg_goal == mode)
                       && fg_current != mode && bg_cur != mode;
    assign leave_hit = (fg_previous == mode && bg_cur != mode && bg_goal != mode)
                       || (bg_last == mode && fg_current != mode && fg_goal != mode)
                       || (bg_last == mode && fg_previous == mode);

    // history chain
    assign tok_valid[0] = (state_reg == ST_SAVE) && (step_reg == '0);
    assign tok_data[0]  = key_reg;

    for (genvar i = 0; i < HISTORY_DEPTH; i++)
    begin : g_cell
        assign cell_ctl[i].shift_up = shift_up;
        assign cell_ctl[i].live     = (count_reg > CNT_W'(i));

        mdts_hist_cell #(.MODE_BITS(MODE_BITS)) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (cell_ctl[i]),
            .key           (key_reg),
            .up_val        (cell_val[(i + 1) % HISTORY_DEPTH]),
            .tok_in_valid  (tok_valid[i]),
            .tok_in_data   (tok_data[i]),
            .val           (cell_val[i]),
            .tok_out_valid (tok_valid[i+1]),
            .tok_out_data  (tok_data[i+1]),
            .absorbed      (absorbed[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        flag_next   = flag_reg;
        popped_next = popped_reg;
        fell_next   = fell_reg;
        step_next   = step_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        shift_up    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    flag_next   = 1'b0;
                    popped_next = '0;
                    fell_next   = 1'b0;
                    case (action)
                        ACT_ENTER:
                        begin
                            flag_next = enter_hit;
                            done_next = 1'b1;
                        end
                        ACT_LEAVE:
                        begin
                            flag_next = leave_hit;
                            done_next = 1'b1;
                        end
                        ACT_SAVE:
                        begin
                            key_next   = mode;
                            step_next  = '0;
                            state_next = ST_SAVE;
                        end
                        ACT_POP:
                        begin
                            state_next = ST_POP;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SAVE:
            begin
                if (|absorbed)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(HISTORY_DEPTH - 1))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (count_reg == '0)
                begin
                    popped_next = default_reg;
                    fell_next   = (default_reg != fg_current);
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    shift_up   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    // entries equal to the fg current mode are dropped
                    if (cell_val[0] != fg_current)
                    begin
                        popped_next = cell_val[0];
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            flag_reg   <= 1'b0;
            popped_reg <= '0;
            fell_reg   <= 1'b0;
            step_reg   <= '0;
            key_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            flag_reg   <= flag_next;
            popped_reg <= popped_next;
            fell_reg   <= fell_next;
            step_reg   <= step_next;
            key_reg    <= key_next;
            count_reg  <= count_next;
        end
    end

    assign done        = done_reg;
    assign check_flag  = flag_reg;
    assign popped_mode = popped_reg;
    assign fell_back   = fell_reg;

endmodule

`default_nettype wire

// ===== design/mdts_checker.sv =====
// port-level checks for the dual mode transition sequencer, bound to the top level
// depends on mdts_pkg and dual_mode_transition_sequencer_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "dual_mode_transition_sequencer_defines.svh"

module mdts_checker
    import mdts_pkg::*;
#(
    parameter int MODE_BITS = 4
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic [ACTION_BITS-1:0] action,
    input wire logic [MODE_BITS-1:0]   mode,
    input wire logic                   done,
    input wire logic [MODE_BITS-1:0]   fg_request,
    input wire logic [MODE_BITS-1:0]   fg_goal,
    input wire logic [MODE_BITS-1:0]   fg_current,
    input wire logic [MODE_BITS-1:0]   fg_previous,
    input wire logic [MODE_BITS-1:0]   fg_kept,
    input wire logic                   check_flag,
    input wire logic [MODE_BITS-1:0]   popped_mode,
    input wire logic                   fell_back,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic [MODE_BITS-1:0]   cfg_data
);

    logic quick_txn;
    logic any_txn;

    assign any_txn   = start && !busy;
    assign quick_txn = any_txn && !(action == ACT_SAVE || action == ACT_POP);

    // single-step transactions answer in the next cycle
    `MDTS_ASSERT_NEXT(a_quick_done, quick_txn, done, "single-step transaction gave no result")

    // a fallback never hands back the current fg mode
    `MDTS_ASSERT_SAME(a_fell_differs, done && fell_back, popped_mode != fg_current,
        "fallback returned the current mode")

    // check flag and popped mode never come from the same transaction
    `MDTS_ASSERT_SAME(a_flag_pop_excl, done && check_flag, popped_mode == '0,
        "check flag and popped mode both set")

    // fg registers only move at the edge that takes a transaction
    `MDTS_ASSERT_NEXT(a_fg_hold, !any_txn,
        $stable(fg_request) && $stable(fg_goal) && $stable(fg_current),
        "fg registers changed without a transaction")

endmodule

bind dual_mode_transition_sequencer mdts_checker #(.MODE_BITS(MODE_BITS)) u_mdts_checker (.*);

`default_nettype wire

// ===== bench/tb_dual_mode_transition_sequencer.sv =====
// self-checking bench for the dual mode transition sequencer
// keeps its own copy of both mode channels and the history and checks every result strobe
// depends on mdts_pkg and dual_mode_transition_sequencer
`timescale 1ns / 1ps

module tb_dual_mode_transition_sequencer;
    import mdts_pkg::*;

    localparam int HDEPTH = 16;
    localparam int MBITS = 4;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 234;
    localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 3'd7;
    localparam logic [MBITS-1:0] MODE_NONE = '0;

    typedef struct packed {
        logic [MBITS-1:0] request;
        logic [MBITS-1:0] goal;
        logic [MBITS-1:0] current;
        logic [MBITS-1:0] last;
        logic [MBITS-1:0] kept;
    } chan_regs_t;

    typedef struct packed {
        chan_regs_t       fg;
        logic             flag;
        logic [MBITS-1:0] popped;
        logic             fell;
    } mode_outcome_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [ACTION_BITS-1:0] action;
    logic [MBITS-1:0]       mode;
    logic                   done;
    logic [MBITS-1:0]       fg_request;
    logic [MBITS-1:0]       fg_goal;
    logic [MBITS-1:0]       fg_current;
    logic [MBITS-1:0]       fg_previous;
    logic [MBITS-1:0]       fg_kept;
    logic                   check_flag;
    logic [MBITS-1:0]       popped_mode;
    logic                   fell_back;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [MBITS-1:0]       cfg_data;

    // shadow state of the block
    chan_regs_t       fg_chan;
    chan_regs_t       bg_chan;
    logic [MBITS-1:0] history_copy [HDEPTH];
    int               history_fill;
    logic [MBITS-1:0] default_copy;

    mode_outcome_t pending_outcomes[$];
    int sender_idle_pct;
    int cmds_sent;
    int results_checked;
    int cfg_writes;
    int error_count;

    dual_mode_transition_sequencer #(
        .HISTORY_DEPTH(HDEPTH),
        .MODE_BITS    (MBITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .mode       (mode),
        .done       (done),
        .fg_request (fg_request),
        .fg_goal    (fg_goal),
        .fg_current (fg_current),
        .fg_previous(fg_previous),
        .fg_kept    (fg_kept),
        .check_flag (check_flag),
        .popped_mode(popped_mode),
        .fell_back  (fell_back),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic chan_regs_t request_chan(chan_regs_t ch, logic [MBITS-1:0] m);
        if (m != MODE_NONE && m != ch.current)
            ch.request = m;
        return ch;
    endfunction

    function automatic chan_regs_t advance_chan(chan_regs_t ch);
        if (ch.last != MODE_NONE)
        begin
            ch.kept = ch.last;
            ch.last = MODE_NONE;
        end
        if (ch.goal != MODE_NONE)
        begin
            ch.last = ch.current;
            ch.current = ch.goal;
        end
        ch.goal = ch.request;
        ch.request = MODE_NONE;
        return ch;
    endfunction

    // applies one accepted command to the shadow state and queues the result it should give
    task automatic compute_mode_outcome(input logic [ACTION_BITS-1:0] act,
                                        input logic [MBITS-1:0] m);
        mode_outcome_t res;
        logic [MBITS-1:0] got;
        int pos;
        bit found;
        res = '0;
        case (act)
            ACT_FG_REQ: fg_chan = request_chan(fg_chan, m);
            ACT_BG_REQ: bg_chan = request_chan(bg_chan, m);
            ACT_TICK:
            begin
                fg_chan = advance_chan(fg_chan);
                bg_chan = advance_chan(bg_chan);
            end
            ACT_ENTER:
                res.flag = (fg_chan.goal == m || bg_chan.goal == m)
                           && fg_chan.current != m && bg_chan.current != m;
            ACT_LEAVE:
                res.flag = (fg_chan.last == m && bg_chan.current != m && bg_chan.goal != m)
                        || (bg_chan.last == m && fg_chan.current != m && fg_chan.goal != m)
                        || (bg_chan.last == m && fg_chan.last == m);
            ACT_SAVE:
            begin
                pos = -1;
                for (int i = 0; i < history_fill; i++)
                    if (pos < 0 && history_copy[i] == m)
                        pos = i;
                if (pos < 0)
                begin
                    if (history_fill < HDEPTH)
                    begin
                        pos = history_fill;
                        history_fill++;
                    end
                    else
                        pos = HDEPTH - 1;
                end
                for (int i = pos; i > 0; i--)
                    history_copy[i] = history_copy[i-1];
                history_copy[0] = m;
            end
            ACT_POP:
            begin
                found = 1'b0;
                while (history_fill != 0 && !found)
                begin
                    got = history_copy[0];
                    for (int i = 0; i + 1 < history_fill; i++)
                        history_copy[i] = history_copy[i+1];
                    history_fill--;
                    if (got != fg_chan.current)
                    begin
                        res.popped = got;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    res.popped = default_copy;
                    res.fell = default_copy != fg_chan.current;
                end
            end
            default: ;
        endcase
        res.fg = fg_chan;
        pending_outcomes.push_back(res);
    endtask

    // one command transaction; start is left high so a following command can go back to back
    task automatic send_cmd(input logic [ACTION_BITS-1:0] act, input logic [MBITS-1:0] m);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < sender_idle_pct)
            gap = $urandom_range(1, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        action <= act;
        mode <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        compute_mode_outcome(act, m);
        cmds_sent++;
    endtask

    task automatic wait_results_settled();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_default_mode(input logic [MBITS-1:0] value);
        wait_results_settled();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        default_copy = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [MBITS-1:0] want,
                               input logic [MBITS-1:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        mode_outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result strobe with no command outstanding");
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("fg_request", want.fg.request, fg_request);
                check_field("fg_goal", want.fg.goal, fg_goal);
                check_field("fg_current", want.fg.current, fg_current);
                check_field("fg_previous", want.fg.last, fg_previous);
                check_field("fg_kept", want.fg.kept, fg_kept);
                check_field("check_flag", MBITS'(want.flag), MBITS'(check_flag));
                check_field("popped_mode", want.popped, popped_mode);
                check_field("fell_back", MBITS'(want.fell), MBITS'(fell_back));
                results_checked++;
            end
        end
    end

    function automatic logic [MBITS-1:0] pick_mode();
        if ($urandom_range(0, 3) == 0)
            return MBITS'($urandom_range(0, 15));
        return MBITS'($urandom_range(1, 6));
    endfunction

    // operand that is likely to hit something held in the channels
    function automatic logic [MBITS-1:0] pick_held_mode();
        case ($urandom_range(0, 5))
            0: return fg_chan.goal;
            1: return bg_chan.goal;
            2: return fg_chan.last;
            3: return bg_chan.last;
            4: return fg_chan.current;
            default: return pick_mode();
        endcase
    endfunction

    task automatic test_unused_and_empty_pop();
        send_cmd(ACT_UNUSED, 4'hf);
        send_cmd(ACT_POP, MODE_NONE);
        send_cmd(ACT_ENTER, MODE_NONE);
    endtask

    task automatic test_channel_stages();
        send_cmd(ACT_FG_REQ, MODE_NONE);
        send_cmd(ACT_FG_REQ, 4'd3);
        send_cmd(ACT_BG_REQ, 4'd3);
        send_cmd(ACT_TICK, 4'd0);
        send_cmd(ACT_ENTER, 4'd3);
        send_cmd(ACT_TICK, 4'hf);
        // request equal to current is dropped
        send_cmd(ACT_FG_REQ, 4'd3);
        send_cmd(ACT_FG_REQ, 4'hf);
        send_cmd(ACT_BG_REQ, 4'd9);
        send_cmd(ACT_TICK, 4'd0);
        send_cmd(ACT_TICK, 4'd0);
        // both channels left mode 3
        send_cmd(ACT_LEAVE, 4'd3);
        send_cmd(ACT_TICK, 4'd0);
    endtask

    task automatic test_history_order();
        send_cmd(ACT_SAVE, MODE_NONE);
        send_cmd(ACT_SAVE, 4'hf);
        send_cmd(ACT_SAVE, MODE_NONE);
        send_cmd(ACT_POP, 4'd0);
        // remaining entry equals fg current, so the pop falls back
        send_cmd(ACT_POP, 4'd0);
    endtask

    task automatic test_default_mode();
        write_default_mode(4'd0);
        send_cmd(ACT_POP, 4'd0);
        write_default_mode(4'hf);
        send_cmd(ACT_POP, 4'd0);
    endtask

    task automatic transition_burst();
        send_cmd(ACT_FG_REQ, pick_held_mode());
        if ($urandom_range(0, 1))
            send_cmd(ACT_BG_REQ, pick_held_mode());
        send_cmd(ACT_TICK, MBITS'($urandom_range(0, 15)));
        send_cmd(ACT_ENTER, pick_held_mode());
        if ($urandom_range(0, 2) != 0)
            send_cmd(ACT_TICK, MBITS'($urandom_range(0, 15)));
        send_cmd(ACT_LEAVE, pick_held_mode());
    endtask

    task automatic history_burst();
        int order [HDEPTH];
        int j, tmp, n;
        if ($urandom_range(0, 5) == 0)
        begin
            // fill the whole history with a shuffled set of modes
            for (int i = 0; i < HDEPTH; i++)
                order[i] = i;
            for (int i = HDEPTH - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < HDEPTH; i++)
                send_cmd(ACT_SAVE, MBITS'(order[i]));
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                send_cmd(ACT_SAVE, $urandom_range(0, 2) == 0 ? fg_chan.current : pick_mode());
        end
        n = $urandom_range(1, history_fill + 2);
        for (int i = 0; i < n; i++)
            send_cmd(ACT_POP, MBITS'($urandom_range(0, 15)));
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            send_cmd(ACTION_BITS'($urandom_range(0, 7)), MBITS'($urandom_range(0, 15)));
    endtask

    task automatic test_random_mix(input int quota);
        int first;
        int kind;
        first = cmds_sent;
        while (cmds_sent - first < quota)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
                transition_burst();
            else if (kind < 8)
                history_burst();
            else
                noise_burst();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_FG_REQ;
        mode = MODE_NONE;
        cfg_valid = 1'b0;
        cfg_data = MODE_NONE;
        fg_chan = '0;
        bg_chan = '0;
        history_fill = 0;
        default_copy = 4'd1;
        sender_idle_pct = 25;
        cmds_sent = 0;
        results_checked = 0;
        cfg_writes = 0;
        error_count = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unused_and_empty_pop();
        test_channel_stages();
        test_history_order();
        test_default_mode();

        write_default_mode(MBITS'($urandom_range(1, 15)));
        sender_idle_pct = 25;
        test_random_mix(PHASE_ITEMS);

        write_default_mode(4'hf);
        sender_idle_pct = 54;
        test_random_mix(PHASE_ITEMS);

        write_default_mode(4'd1);
        sender_idle_pct = 0;
        test_random_mix(PHASE_ITEMS);

        wait_results_settled();
        repeat (HDEPTH + 4) @(posedge clk);

        $display("%0d commands sent and %0d results checked over %0d default mode writes",
                 cmds_sent, results_checked, cfg_writes);
        $display("covered requests, ticks, enter and leave checks, saves, pops and fallback");
        if (error_count == 0 && pending_outcomes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
